FILE: sv/elrt_pkg.sv
// ----------------------------------------------------------------------------
// elrt_pkg: shared types and constants of the embedded and raw text lexer
// Command codes, token kinds, scan phases, character codes and the
// classified transaction that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package elrt_pkg;

   // command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_CHAR  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // token kinds
   localparam logic [1:0] KIND_BACKTICK = 2'd0;
   localparam logic [1:0] KIND_QUOTE    = 2'd1;
   localparam logic [1:0] KIND_RAW      = 2'd2;

   // close tag peek limit
   localparam logic [2:0] PEEK_MAX    = 3'd7;
   localparam logic [2:0] SCRIPT_LEN  = 3'd6;
   localparam logic [2:0] STYLE_LEN   = 3'd5;

   // character codes
   localparam logic [20:0] CH_AT        = 21'h40;
   localparam logic [20:0] CH_LBRACE    = 21'h7B;
   localparam logic [20:0] CH_BACKTICK  = 21'h60;
   localparam logic [20:0] CH_QUOTE     = 21'h22;
   localparam logic [20:0] CH_BACKSLASH = 21'h5C;
   localparam logic [20:0] CH_LT        = 21'h3C;
   localparam logic [20:0] CH_SLASH     = 21'h2F;
   localparam logic [20:0] CH_UNDER     = 21'h5F;
   localparam logic [20:0] CH_UPPER_A   = 21'h41;
   localparam logic [20:0] CH_UPPER_Z   = 21'h5A;
   localparam logic [20:0] CH_LOWER_A   = 21'h61;
   localparam logic [20:0] CH_LOWER_Z   = 21'h7A;
   localparam logic [20:0] CH_DIGIT_0   = 21'h30;
   localparam logic [20:0] CH_DIGIT_9   = 21'h39;
   localparam logic [20:0] CASE_OFFSET  = 21'd32;

   // close tag names, element 0 is the first letter
   localparam logic [0:5][7:0] SCRIPT_TAG = "script";
   localparam logic [0:4][7:0] STYLE_TAG  = "style";

   // scan phases
   typedef enum logic [2:0] {
      PH_NORMAL = 3'd0,
      PH_AT     = 3'd1,
      PH_ESC    = 3'd2,
      PH_LT     = 3'd3,
      PH_PEEK   = 3'd4
   } phase_type;

   // classified transaction
   typedef struct packed {
      logic [1:0] cmd;
      logic       mask_zero;
      logic [1:0] kind;
      logic       is_at;
      logic       is_lbrace;
      logic       is_backtick;
      logic       is_quote;
      logic       is_backslash;
      logic       is_lt;
      logic       is_slash;
      logic       is_ident;
      logic [5:0] script_hit;
      logic [4:0] style_hit;
   } item_type;

endpackage

FILE: sv/embedded_and_raw_text_lexer_unit.sv
// ----------------------------------------------------------------------------
// embedded_and_raw_text_lexer_unit: text token lexer for embedded markup
// Scans backtick, double-quote or raw script/style text and reports the
// token end position when the scan closes.
// ----------------------------------------------------------------------------
// req_*: start (with valid_mask), one character (char_code) or end of input,
//   one per transaction, accepted when req_valid is high and req_stall low.
// rsp_*: one result per finished scan (delimiter, '@{', close tag, end of
//   input, or a start with an empty mask), accepted on rsp_valid, !rsp_stall.
// Throughput: one transaction per cycle, set by the scan state update in the
//   back end, while no stalled result holds the back end.
// Path: a closing transaction passes through a queue entry and then the
//   result register to rsp_valid; transactions queued ahead of it go first.
// Reset: clears the queue, the scan state and the result valid flag; no scan
//   is open afterwards.
// Stall: a stalled result holds; the back end stops, the queue fills and
//   req_stall rises once two transactions wait.
// ----------------------------------------------------------------------------
module embedded_and_raw_text_lexer_unit #(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  req_valid_mask,
   input  logic [20:0] req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_token_found,
   output logic [1:0]  rsp_symbol,
   output logic [15:0] rsp_token_length,
   output logic        rsp_length_saturated
);
   import elrt_pkg::*;

   item_type push_data;
   item_type pop_data;
   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;

   // intake and classification
   elrt_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_valid_mask (req_valid_mask),
      .req_char_code  (req_char_code),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (push_data)
   );

   // decoupling queue
   elrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // scan engine and result register
   elrt_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .item                 (pop_data),
      .q_empty              (q_empty),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_token_found      (rsp_token_found),
      .rsp_symbol           (rsp_symbol),
      .rsp_token_length     (rsp_token_length),
      .rsp_length_saturated (rsp_length_saturated)
   );

endmodule

FILE: sv/elrt_front.sv
// ----------------------------------------------------------------------------
// elrt_front: request intake and character classification
// Accepts request transactions while the queue has room and turns each one
// into flags the back end needs: start kind, delimiters and tag letter hits.
// ----------------------------------------------------------------------------
module elrt_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [2:0]        req_valid_mask,
   input  logic [20:0]       req_char_code,
   input  logic              q_full,
   output logic              q_push,
   output elrt_pkg::item_type q_data
);
   import elrt_pkg::*;

   logic [20:0] lower_code;
   logic        is_upper;
   logic        is_lower;
   logic        is_digit;

   // handshake toward the queue
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // letter classes and case folding
   assign is_upper   = (req_char_code >= CH_UPPER_A) && (req_char_code <= CH_UPPER_Z);
   assign is_lower   = (req_char_code >= CH_LOWER_A) && (req_char_code <= CH_LOWER_Z);
   assign is_digit   = (req_char_code >= CH_DIGIT_0) && (req_char_code <= CH_DIGIT_9);
   assign lower_code = is_upper ? req_char_code + CASE_OFFSET : req_char_code;

   // classified transaction
   always_comb begin
      q_data              = '0;
      q_data.cmd          = req_cmd;
      q_data.mask_zero    = (req_valid_mask == 3'd0);
      priority if (req_valid_mask[0]) begin
         q_data.kind = KIND_BACKTICK;
      end else if (req_valid_mask[1]) begin
         q_data.kind = KIND_QUOTE;
      end else begin
         q_data.kind = KIND_RAW;
      end
      q_data.is_at        = (req_char_code == CH_AT);
      q_data.is_lbrace    = (req_char_code == CH_LBRACE);
      q_data.is_backtick  = (req_char_code == CH_BACKTICK);
      q_data.is_quote     = (req_char_code == CH_QUOTE);
      q_data.is_backslash = (req_char_code == CH_BACKSLASH);
      q_data.is_lt        = (req_char_code == CH_LT);
      q_data.is_slash     = (req_char_code == CH_SLASH);
      q_data.is_ident     = is_upper || is_lower || is_digit || (req_char_code == CH_UNDER);
      for (int k = 0; k < 6; k++) begin
         q_data.script_hit[k] = (lower_code == {13'd0, SCRIPT_TAG[k]});
      end
      for (int k = 0; k < 5; k++) begin
         q_data.style_hit[k] = (lower_code == {13'd0, STYLE_TAG[k]});
      end
   end

endmodule

FILE: sv/elrt_queue.sv
// ----------------------------------------------------------------------------
// elrt_queue: two-entry queue between front and back end
// Lets the front keep accepting while the back end waits on the receiver.
// ----------------------------------------------------------------------------
module elrt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  elrt_pkg::item_type push_data,
   output logic               full,
   input  logic               pop,
   output elrt_pkg::item_type pop_data,
   output logic               empty
);
   import elrt_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");
   a_level: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !full) |=> !empty)
      else $error("queue lost a transaction");
`endif

endmodule

FILE: sv/elrt_back.sv
// ----------------------------------------------------------------------------
// elrt_back: scan state and result register
// Carries out one classified transaction per cycle on the scan state, unless
// a stalled result holds it, and loads the result register when a scan finishes.
// ----------------------------------------------------------------------------
module elrt_back #(
   parameter int LENGTH_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  elrt_pkg::item_type item,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_token_found,
   output logic [1:0]         rsp_symbol,
   output logic [15:0]        rsp_token_length,
   output logic               rsp_length_saturated
);
   import elrt_pkg::*;

   localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

   // scan state
   logic                   scan_active_ff, scan_active_in;
   logic [1:0]             scan_kind_ff, scan_kind_in;
   phase_type              phase_ff, phase_in;
   logic                   consumed_ff, consumed_in;
   logic [LENGTH_BITS-1:0] position_ff, position_in;
   logic [LENGTH_BITS-1:0] marked_end_ff, marked_end_in;
   logic [2:0]             peek_count_ff, peek_count_in;
   logic                   script_match_ff, script_match_in;
   logic                   style_match_ff, style_match_in;
   logic                   finish_in;

   // result register
   logic                   rsp_valid_ff;
   logic                   found_ff, found_in;
   logic [1:0]             symbol_ff, symbol_in;
   logic [15:0]            length_ff, length_in;
   logic                   saturated_ff, saturated_in;
   logic [LENGTH_BITS+15:0] mark_ext;

   assign q_pop = !q_empty && (!rsp_valid_ff || !rsp_stall);

   // next scan state for the transaction at the queue head
   always_comb begin
      logic do_normal;
      logic plain;
      logic is_delim;
      do_normal       = 1'b0;
      plain           = 1'b0;
      is_delim        = 1'b0;
      finish_in       = 1'b0;
      scan_active_in  = scan_active_ff;
      scan_kind_in    = scan_kind_ff;
      phase_in        = phase_ff;
      consumed_in     = consumed_ff;
      position_in     = position_ff;
      marked_end_in   = marked_end_ff;
      peek_count_in   = peek_count_ff;
      script_match_in = script_match_ff;
      style_match_in  = style_match_ff;

      if (item.cmd == CMD_START) begin
         scan_active_in  = 1'b0;
         scan_kind_in    = KIND_BACKTICK;
         phase_in        = PH_NORMAL;
         consumed_in     = 1'b0;
         position_in     = '0;
         marked_end_in   = '0;
         peek_count_in   = 3'd0;
         script_match_in = 1'b0;
         style_match_in  = 1'b0;
         if (item.mask_zero) begin
            finish_in = 1'b1;
         end else begin
            scan_kind_in   = item.kind;
            scan_active_in = 1'b1;
         end
      end else if (scan_active_ff && item.cmd == CMD_CHAR) begin
         unique case (phase_ff)
            PH_AT: begin
               if (item.is_lbrace) begin
                  finish_in = 1'b1;
               end else begin
                  consumed_in = 1'b1;
                  do_normal   = 1'b1;
               end
            end
            PH_ESC: begin
               if (position_in != POS_MAX) position_in = position_in + 1'b1;
               consumed_in   = 1'b1;
               marked_end_in = position_in;
               phase_in      = PH_NORMAL;
            end
            PH_LT: begin
               if (item.is_slash) begin
                  if (position_in != POS_MAX) position_in = position_in + 1'b1;
                  phase_in        = PH_PEEK;
                  peek_count_in   = 3'd0;
                  script_match_in = 1'b1;
                  style_match_in  = 1'b1;
               end else begin
                  consumed_in = 1'b1;
                  do_normal   = 1'b1;
               end
            end
            PH_PEEK: begin
               if (item.is_lt) begin
                  if ((script_match_ff && peek_count_ff >= SCRIPT_LEN) ||
                      (style_match_ff && peek_count_ff >= STYLE_LEN)) begin
                     finish_in = 1'b1;
                  end else begin
                     consumed_in   = 1'b1;
                     marked_end_in = position_in;
                     do_normal     = 1'b1;
                  end
               end else begin
                  // one more tag letter
                  if (peek_count_ff < SCRIPT_LEN) begin
                     script_match_in = script_match_ff && item.script_hit[peek_count_ff];
                  end else if (peek_count_ff == SCRIPT_LEN) begin
                     script_match_in = script_match_ff && !item.is_ident;
                  end
                  if (peek_count_ff < STYLE_LEN) begin
                     style_match_in = style_match_ff && item.style_hit[peek_count_ff];
                  end else if (peek_count_ff == STYLE_LEN) begin
                     style_match_in = style_match_ff && !item.is_ident;
                  end
                  peek_count_in = peek_count_ff + 3'd1;
                  if (position_in != POS_MAX) position_in = position_in + 1'b1;
                  if (peek_count_in == PEEK_MAX) begin
                     if ((script_match_in && peek_count_in >= SCRIPT_LEN) ||
                         (style_match_in && peek_count_in >= STYLE_LEN)) begin
                        finish_in = 1'b1;
                     end else begin
                        consumed_in   = 1'b1;
                        marked_end_in = position_in;
                        phase_in      = PH_NORMAL;
                     end
                  end
               end
            end
            default: begin
               do_normal = 1'b1;
            end
         endcase

         // ordinary character handling
         if (do_normal) begin
            phase_in = PH_NORMAL;
            is_delim = (scan_kind_ff == KIND_BACKTICK) ? item.is_backtick : item.is_quote;
            priority if (item.is_at) begin
               marked_end_in = position_in;
               if (position_in != POS_MAX) position_in = position_in + 1'b1;
               phase_in = PH_AT;
            end else if (scan_kind_ff == KIND_RAW) begin
               if (item.is_lt) begin
                  marked_end_in = position_in;
                  if (position_in != POS_MAX) position_in = position_in + 1'b1;
                  phase_in = PH_LT;
               end else begin
                  plain = 1'b1;
               end
            end else if (is_delim) begin
               marked_end_in = position_in;
               finish_in     = 1'b1;
            end else if (item.is_backslash) begin
               if (position_in != POS_MAX) position_in = position_in + 1'b1;
               phase_in = PH_ESC;
            end else begin
               plain = 1'b1;
            end
            if (plain) begin
               if (position_in != POS_MAX) position_in = position_in + 1'b1;
               consumed_in   = 1'b1;
               marked_end_in = position_in;
            end
         end
      end else if (scan_active_ff && item.cmd == CMD_END) begin
         if (phase_ff == PH_PEEK &&
             ((script_match_ff && peek_count_ff >= SCRIPT_LEN) ||
              (style_match_ff && peek_count_ff >= STYLE_LEN))) begin
            finish_in = 1'b1;
         end else begin
            if (phase_ff != PH_NORMAL) consumed_in = 1'b1;
            marked_end_in = position_in;
            finish_in     = 1'b1;
         end
      end

      if (finish_in) begin
         scan_active_in = 1'b0;
         phase_in       = PH_NORMAL;
      end
   end

   // result fields of a finished scan
   assign mark_ext = {16'd0, marked_end_in};

   always_comb begin
      found_in     = consumed_in;
      symbol_in    = consumed_in ? scan_kind_in : KIND_BACKTICK;
      length_in    = consumed_in ? mark_ext[15:0] : 16'd0;
      saturated_in = (position_in == POS_MAX);
   end

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff  <= 1'b0;
         scan_kind_ff    <= KIND_BACKTICK;
         phase_ff        <= PH_NORMAL;
         consumed_ff     <= 1'b0;
         position_ff     <= '0;
         marked_end_ff   <= '0;
         peek_count_ff   <= 3'd0;
         script_match_ff <= 1'b0;
         style_match_ff  <= 1'b0;
      end else if (q_pop) begin
         scan_active_ff  <= scan_active_in;
         scan_kind_ff    <= scan_kind_in;
         phase_ff        <= phase_in;
         consumed_ff     <= consumed_in;
         position_ff     <= position_in;
         marked_end_ff   <= marked_end_in;
         peek_count_ff   <= peek_count_in;
         script_match_ff <= script_match_in;
         style_match_ff  <= style_match_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= finish_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (q_pop && finish_in) begin
         found_ff     <= found_in;
         symbol_ff    <= symbol_in;
         length_ff    <= length_in;
         saturated_ff <= saturated_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_token_found      = found_ff;
   assign rsp_symbol           = symbol_ff;
   assign rsp_token_length     = length_ff;
   assign rsp_length_saturated = saturated_ff;

`ifndef SYNTHESIS
   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !q_pop)
      else $error("transaction taken while result is stalled");
   a_phase_needs_scan: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_NORMAL) |-> scan_active_ff)
      else $error("phase set with no scan open");
   a_peek_raw_only: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PEEK) |-> (scan_kind_ff == KIND_RAW && peek_count_ff != PEEK_MAX))
      else $error("bad close tag peek state");
   a_mark_behind: assert property (@(posedge clock) disable iff (reset)
      marked_end_ff <= position_ff)
      else $error("marked end past position");
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (q_pop && finish_in) |=> rsp_valid_ff)
      else $error("finished scan gave no result");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the embedded and raw text lexer
// Streams start, character and end transactions into the lexer, predicts
// every scan result with a behavioral copy of the scan state, and compares
// each result field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import elrt_pkg::*;

   localparam int LEN_BITS = 16;
   localparam logic [LEN_BITS-1:0] POS_LIMIT = '1;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1450;
   localparam int STAGE_ITEMS = 200;
   localparam int IDLE_LIMIT = 2000;
   localparam int PRINT_LIMIT = 100;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   typedef struct packed {
      logic        found;
      logic [1:0]  symbol;
      logic [15:0] length;
      logic        saturated;
   } token_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [2:0]  req_valid_mask;
   logic [20:0] req_char_code;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_token_found;
   logic [1:0]  rsp_symbol;
   logic [15:0] rsp_token_length;
   logic        rsp_length_saturated;

   // expected scan results, oldest first
   token_result_type token_q[$];
   token_result_type want_tok;

   // predicted scan state
   logic                lex_open;
   logic [1:0]          lex_kind;
   phase_type           lex_phase;
   logic                lex_consumed;
   logic [LEN_BITS-1:0] lex_pos;
   logic [LEN_BITS-1:0] lex_end;
   logic [2:0]          lex_peek_n;
   logic                script_live;
   logic                style_live;

   int             sent_items = 0;
   int             fail_count = 0;
   int             idle_cycles = 0;
   int             gap_pct = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   logic [3:0]     stall_tick = '0;

   embedded_and_raw_text_lexer_unit #(
      .LENGTH_BITS(LEN_BITS)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_valid_mask       (req_valid_mask),
      .req_char_code        (req_char_code),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_token_found      (rsp_token_found),
      .rsp_symbol           (rsp_symbol),
      .rsp_token_length     (rsp_token_length),
      .rsp_length_saturated (rsp_length_saturated)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // scan predictor
   // ---------------------------------------------------------------------
   function automatic void lex_clear();
      lex_open     = 1'b0;
      lex_kind     = KIND_BACKTICK;
      lex_phase    = PH_NORMAL;
      lex_consumed = 1'b0;
      lex_pos      = '0;
      lex_end      = '0;
      lex_peek_n   = '0;
      script_live  = 1'b0;
      style_live   = 1'b0;
   endfunction

   // position counter holds at its maximum
   function automatic void pos_step();
      if (lex_pos != POS_LIMIT) lex_pos = lex_pos + 1'b1;
   endfunction

   function automatic void close_scan();
      token_result_type r;
      r.found     = lex_consumed;
      r.symbol    = lex_consumed ? lex_kind : '0;
      r.length    = lex_consumed ? 16'(lex_end) : '0;
      r.saturated = (lex_pos == POS_LIMIT);
      token_q.push_back(r);
      lex_open  = 1'b0;
      lex_phase = PH_NORMAL;
   endfunction

   function automatic bit ident_code(input logic [20:0] c);
      return c == CH_UNDER || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
   endfunction

   function automatic bit tag_closed();
      return (script_live && lex_peek_n >= SCRIPT_LEN) || (style_live && lex_peek_n >= STYLE_LEN);
   endfunction

   // one peeked character of a possible close tag, letters folded to lower case
   function automatic void tag_letter(input logic [20:0] c);
      logic [20:0] low;
      low = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
      if (lex_peek_n < SCRIPT_LEN) begin
         script_live = script_live && low == 21'(SCRIPT_TAG[lex_peek_n]);
      end else if (lex_peek_n == SCRIPT_LEN) begin
         script_live = script_live && !ident_code(c);
      end
      if (lex_peek_n < STYLE_LEN) begin
         style_live = style_live && low == 21'(STYLE_TAG[lex_peek_n]);
      end else if (lex_peek_n == STYLE_LEN) begin
         style_live = style_live && !ident_code(c);
      end
      lex_peek_n = lex_peek_n + 1'b1;
   endfunction

   // character in the normal phase
   function automatic void plain_char(input logic [20:0] c);
      lex_phase = PH_NORMAL;
      if (c == CH_AT) begin
         lex_end = lex_pos;
         pos_step();
         lex_phase = PH_AT;
         return;
      end
      if (lex_kind == KIND_RAW) begin
         if (c == CH_LT) begin
            lex_end = lex_pos;
            pos_step();
            lex_phase = PH_LT;
            return;
         end
      end else begin
         if (c == ((lex_kind == KIND_BACKTICK) ? CH_BACKTICK : CH_QUOTE)) begin
            lex_end = lex_pos;
            close_scan();
            return;
         end
         if (c == CH_BACKSLASH) begin
            pos_step();
            lex_phase = PH_ESC;
            return;
         end
      end
      pos_step();
      lex_consumed = 1'b1;
      lex_end = lex_pos;
   endfunction

   function automatic void char_step(input logic [20:0] c);
      case (lex_phase)
         PH_AT: begin
            if (c == CH_LBRACE) begin
               close_scan();
            end else begin
               lex_consumed = 1'b1;
               plain_char(c);
            end
         end
         PH_ESC: begin
            pos_step();
            lex_consumed = 1'b1;
            lex_end = lex_pos;
            lex_phase = PH_NORMAL;
         end
         PH_LT: begin
            if (c == CH_SLASH) begin
               pos_step();
               lex_phase   = PH_PEEK;
               lex_peek_n  = '0;
               script_live = 1'b1;
               style_live  = 1'b1;
            end else begin
               lex_consumed = 1'b1;
               plain_char(c);
            end
         end
         PH_PEEK: begin
            if (c == CH_LT) begin
               // a new '<' cuts the peek short
               if (tag_closed()) begin
                  close_scan();
               end else begin
                  lex_consumed = 1'b1;
                  lex_end = lex_pos;
                  plain_char(c);
               end
            end else begin
               tag_letter(c);
               pos_step();
               if (lex_peek_n >= PEEK_MAX) begin
                  if (tag_closed()) begin
                     close_scan();
                  end else begin
                     lex_consumed = 1'b1;
                     lex_end = lex_pos;
                     lex_phase = PH_NORMAL;
                  end
               end
            end
         end
         default: plain_char(c);
      endcase
   endfunction

   function automatic void end_step();
      if (lex_phase == PH_PEEK && tag_closed()) begin
         close_scan();
      end else begin
         if (lex_phase != PH_NORMAL) lex_consumed = 1'b1;
         lex_end = lex_pos;
         close_scan();
      end
   endfunction

   // advance the prediction by one accepted transaction
   function automatic void predict_token(input logic [1:0] cmd, input logic [2:0] mask,
                                         input logic [20:0] ch);
      case (cmd)
         CMD_START: begin
            lex_clear();
            if (mask == '0) begin
               close_scan();
            end else begin
               lex_kind = mask[0] ? KIND_BACKTICK : (mask[1] ? KIND_QUOTE : KIND_RAW);
               lex_open = 1'b1;
            end
         end
         CMD_CHAR: begin
            if (lex_open) char_step(ch);
         end
         CMD_END: begin
            if (lex_open) end_step();
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (fail_count < PRINT_LIMIT) begin
         $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_q.size() == 0) begin
            report_mismatch("result with none pending", 1, 0);
         end else begin
            want_tok = token_q.pop_front();
            if (rsp_token_found !== want_tok.found)
               report_mismatch("token_found", rsp_token_found, want_tok.found);
            if (rsp_symbol !== want_tok.symbol)
               report_mismatch("symbol", rsp_symbol, want_tok.symbol);
            if (rsp_token_length !== want_tok.length)
               report_mismatch("token_length", rsp_token_length, want_tok.length);
            if (rsp_length_saturated !== want_tok.saturated)
               report_mismatch("length_saturated", rsp_length_saturated, want_tok.saturated);
         end
      end
   end

   // result stall pattern
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 30);
         STALL_PERIODIC: rsp_stall <= (stall_tick < 4'd11);
         default:        rsp_stall <= ($urandom_range(0, 99) < 80);
      endcase
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   // one transaction, with burst gaps, held until accepted
   task automatic send_item(input logic [1:0] cmd, input logic [2:0] mask,
                            input logic [20:0] ch);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 99) < gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_valid_mask <= mask;
      req_char_code  <= ch;
      do @(posedge clock); while (req_stall);
      sent_items++;
      predict_token(cmd, mask, ch);
   endtask

   task automatic send_start(input logic [2:0] mask);
      send_item(CMD_START, mask, 21'($urandom_range(0, 21'h10FFFF)));
   endtask

   task automatic send_char(input logic [20:0] ch);
      send_item(CMD_CHAR, 3'($urandom), ch);
   endtask

   task automatic send_end();
      send_item(CMD_END, 3'($urandom), 21'($urandom_range(0, 21'h10FFFF)));
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_char(21'(s[i]));
   endtask

   // hold off the sender until every pending result is in
   task automatic wait_for_tokens();
      @(negedge clock);
      req_valid <= 1'b0;
      while (token_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic [20:0] plain_code();
      case ($urandom_range(0, 3))
         0:       return 21'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
         1:       return 21'($urandom_range(32, 126));
         2:       return 21'($urandom_range(0, 127));
         default: return 21'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
      endcase
   endfunction

   // any code point, including wide codes whose low byte looks special
   function automatic logic [20:0] any_code();
      case ($urandom_range(0, 2))
         0:       return 21'($urandom_range(0, 21'h10FFFF));
         1:       return 21'($urandom_range(0, 21'hFFFF));
         default: return 21'(($urandom_range(1, 16) << 16) | plain_code());
      endcase
   endfunction

   // close tag attempt: random case, sometimes truncated or broken
   task automatic send_close_tag();
      string       name;
      int          keep;
      logic [20:0] c;
      if ($urandom_range(0, 1)) begin
         name = "script";
      end else begin
         name = "style";
      end
      keep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, name.len()) : name.len();
      send_char(CH_LT);
      if ($urandom_range(0, 9) != 0) send_char(CH_SLASH);
      for (int i = 0; i < keep; i++) begin
         c = 21'(name[i]);
         if ($urandom_range(0, 1)) c = c - CASE_OFFSET;
         send_char(c);
      end
      case ($urandom_range(0, 5))
         0: send_char(21'($urandom_range(32, 47)));
         1: send_char($urandom_range(0, 1) ? CH_UNDER : 21'($urandom_range(CH_DIGIT_0, CH_DIGIT_9)));
         2: send_char(CH_LT);
         3: send_end();
         4: ;
         default: send_char(any_code());
      endcase
   endtask

   task automatic send_fragment();
      case ($urandom_range(0, 11))
         0, 1, 2, 3: repeat ($urandom_range(1, 6)) send_char(plain_code());
         4: begin
            send_char(CH_AT);
            send_char(plain_code());
         end
         5: begin
            send_char(CH_AT);
            send_char(CH_LBRACE);
         end
         6: begin
            send_char(CH_BACKSLASH);
            send_char($urandom_range(0, 1) ? plain_code() : any_code());
         end
         7: send_char($urandom_range(0, 1) ? CH_BACKTICK : CH_QUOTE);
         8, 9: send_close_tag();
         10: begin
            send_char(CH_LT);
            send_char(plain_code());
         end
         default: send_char(any_code());
      endcase
   endtask

   // one well-formed scan with random content
   task automatic random_scan();
      logic [2:0] mask;
      case ($urandom_range(0, 19))
         0:               mask = '0;
         1, 2, 3, 4, 5, 6: mask = 3'b100;
         default:         mask = 3'($urandom_range(1, 7));
      endcase
      send_start(mask);
      repeat ($urandom_range(0, 10)) send_fragment();
      if ($urandom_range(0, 1)) send_end();
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      // empty mask gives not found at once
      send_start('0);
      // no scan open, and the unused command
      send_char(CH_LOWER_A);
      send_end();
      send_item(CMD_UNUSED, '1, '1);
      // backtick text with an escaped delimiter
      send_start(3'b001);
      send_char(CH_LOWER_A);
      send_char(CH_BACKSLASH);
      send_char(CH_BACKTICK);
      send_char(CH_BACKTICK);
      // empty quote text at end of input
      send_start(3'b010);
      send_end();
      // quote text stops before an embedded expression
      send_start(3'b110);
      send_char(CH_LOWER_Z);
      send_char(CH_AT);
      send_char(CH_LBRACE);
      // restart drops the raw scan; wide codes are plain content
      send_start(3'b100);
      send_char(CH_LOWER_Z);
      send_start(3'b111);
      send_char(21'h10FFFF);
      send_char(CH_BACKTICK | 21'h100000);
      send_end();
      // raw text, upper case close tag cut short by end of input
      send_start(3'b100);
      send_char(CH_LOWER_A);
      send_text("</STYLE");
      send_end();
      wait_for_tokens();
   endtask

   task automatic test_random_scans();
      int stage;
      int stop;
      for (stage = 0; sent_items < ITEM_TARGET; stage++) begin
         // first stage runs with no idling on either side
         if (stage == 0) begin
            gap_pct = 0;
            stall_mode = STALL_NONE;
         end else begin
            gap_pct = 25 * $urandom_range(0, 4);
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         end
         stop = sent_items + STAGE_ITEMS;
         while (sent_items < stop && sent_items < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0)
               send_item(2'($urandom_range(0, 3)), 3'($urandom),
                         21'($urandom_range(0, 21'h10FFFF)));
            else
               random_scan();
         end
         wait_for_tokens();
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_START;
      req_valid_mask = '0;
      req_char_code  = '0;
      lex_clear();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_scans();

      wait_for_tokens();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: embedded_and_raw_text_lexer_unit.f
sv/elrt_pkg.sv
sv/elrt_front.sv
sv/elrt_queue.sv
sv/elrt_back.sv
sv/embedded_and_raw_text_lexer_unit.sv
tb/testbench.sv
